FILE: src/max_interval_pair_tracker_defines.svh
// Assertion macros used by the checker of the interval tracker.
`ifndef MAX_INTERVAL_PAIR_TRACKER_DEFINES_SVH
`define MAX_INTERVAL_PAIR_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MIPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MIPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/mipt_pkg.sv
package mipt_pkg;

   // Field widths.
   localparam int NUM_PAIRS   = 6;
   localparam int PAIR_W      = 3;
   localparam int EVENT_ID_W  = 8;
   localparam int CPU_W       = 3;
   localparam int SEQ_W       = 32;
   localparam int TIME_W      = 64;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 3;

   // Command codes.
   localparam logic CMD_EVENT = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_NONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NEW_MAX = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNREG   = 2'd2;

   // Pairs that accept a non-real-time end with the next sequence number.
   localparam logic [PAIR_W-1:0] PAIR_TICK    = 3'd4;
   localparam logic [PAIR_W-1:0] PAIR_RESCHED = 3'd5;

   // Start ids after reset.
   localparam logic [EVENT_ID_W-1:0] START_ID_RESET [NUM_PAIRS] =
      '{8'd100, 8'd102, 8'd104, 8'd106, 8'd110, 8'd190};

   // Part of an entry that only a start event or the power-up clear writes.
   typedef struct packed {
      logic              seen;
      logic [SEQ_W-1:0]  start_seq;
      logic [TIME_W-1:0] start_time;
   } held_type;

   // Part of an entry that the clear command also wipes.
   typedef struct packed {
      logic              waiting;
      logic [TIME_W-1:0] max_interval;
   } live_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_LOOKUP,
      ST_SEQ,
      ST_INTERVAL,
      ST_COMPARE,
      ST_CLEAR,
      ST_RESULT
   } state_type;

   // Operand pairs of the shared subtractor.
   typedef enum logic [1:0] {
      ALU_SEQ,
      ALU_INTERVAL,
      ALU_MAX
   } alu_sel_type;

   // Sequencer to datapath.
   typedef struct packed {
      logic        idle;
      logic        lookup;
      logic        seq_step;
      logic        iv_step;
      logic        cmp_step;
      logic        sweep_clear;
      logic        sweep_init;
      logic        result;
      alu_sel_type alu_sel;
   } ctrl_type;

   // Datapath to sequencer.
   typedef struct packed {
      logic accept;
      logic cmd_clear;
      logic unregistered;
      logic is_start;
      logic end_match;
      logic sweep_last;
      logic out_free;
   } flags_type;

endpackage

FILE: src/mipt_sub_unit.sv
module mipt_sub_unit (
   input  logic [mipt_pkg::TIME_W-1:0] minuend,
   input  logic [mipt_pkg::TIME_W-1:0] subtrahend,
   output logic [mipt_pkg::TIME_W-1:0] diff,
   output logic                        borrow
);
   import mipt_pkg::*;

   logic [TIME_W:0] wide;

   // One 64-bit subtract; the borrow doubles as an unsigned less-than.
   assign wide   = {1'b0, minuend} - {1'b0, subtrahend};
   assign diff   = wide[TIME_W-1:0];
   assign borrow = wide[TIME_W];

endmodule

FILE: src/mipt_entry_store.sv
module mipt_entry_store #(
   parameter int DEPTH  = 48,
   parameter int ADDR_W = 6
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output mipt_pkg::held_type held_rd,
   output mipt_pkg::live_type live_rd,
   input  logic               held_we,
   input  logic               live_we,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  mipt_pkg::held_type held_wdata,
   input  mipt_pkg::live_type live_wdata
);
   import mipt_pkg::*;

   held_type held_mem [DEPTH];
   live_type live_mem [DEPTH];
   held_type held_rd_ff;
   live_type live_rd_ff;

   // Held part: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (held_we) begin
         held_mem[wr_addr] <= held_wdata;
      end
      if (rd_en) begin
         held_rd_ff <= held_mem[rd_addr];
      end
   end

   // Live part: written separately so a clear leaves the held part alone.
   always_ff @(posedge clock) begin
      if (live_we) begin
         live_mem[wr_addr] <= live_wdata;
      end
      if (rd_en) begin
         live_rd_ff <= live_mem[rd_addr];
      end
   end

   assign held_rd = held_rd_ff;
   assign live_rd = live_rd_ff;

endmodule

FILE: src/mipt_seq.sv
module mipt_seq (
   input  logic                clock,
   input  logic                reset,
   input  mipt_pkg::flags_type flags,
   output mipt_pkg::ctrl_type  ctrl
);
   import mipt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (flags.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (flags.accept) state_in = flags.cmd_clear ? ST_CLEAR : ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = flags.unregistered ? ST_RESULT : ST_SEQ;
         end
         ST_SEQ: begin
            if (!flags.is_start && flags.end_match) begin
               state_in = ST_INTERVAL;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_INTERVAL: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            state_in = ST_RESULT;
         end
         ST_CLEAR: begin
            if (flags.sweep_last) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (flags.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // Outputs depend on the state alone.
   always_comb begin
      ctrl         = '0;
      ctrl.alu_sel = ALU_SEQ;
      case (state_ff)
         ST_INIT:     ctrl.sweep_init  = 1'b1;
         ST_IDLE:     ctrl.idle        = 1'b1;
         ST_LOOKUP:   ctrl.lookup      = 1'b1;
         ST_SEQ:      ctrl.seq_step    = 1'b1;
         ST_INTERVAL: begin
            ctrl.iv_step = 1'b1;
            ctrl.alu_sel = ALU_INTERVAL;
         end
         ST_COMPARE: begin
            ctrl.cmp_step = 1'b1;
            ctrl.alu_sel  = ALU_MAX;
         end
         ST_CLEAR:    ctrl.sweep_clear = 1'b1;
         ST_RESULT:   ctrl.result      = 1'b1;
         default: begin
            ctrl.alu_sel = ALU_SEQ;
         end
      endcase
   end

endmodule

FILE: src/max_interval_pair_tracker.sv
// Tracks the largest start-to-end time of six event pairs on each CPU and
// returns exactly one result word for each request word. A shared 64-bit
// subtractor is stepped by a small sequencer through the sequence compare,
// the interval and the maximum compare, and the entry memory has a
// registered read; the input stalls until the result is in the output
// register. A clear command walks all NUM_CPUS*6 entries, one per cycle.
// After reset the block first zeroes the whole memory, during which
// req_stall is high; configuration writes are taken at any time.
module max_interval_pair_tracker #(
   parameter int NUM_CPUS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cmd,
   input  logic [mipt_pkg::EVENT_ID_W-1:0]  req_event_id,
   input  logic [mipt_pkg::CPU_W-1:0]       req_cpu_index,
   input  logic [mipt_pkg::SEQ_W-1:0]       req_seq_number,
   input  logic                             req_is_realtime,
   input  logic [mipt_pkg::TIME_W-1:0]      req_time_value,
   // Response channel.
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mipt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [mipt_pkg::PAIR_W-1:0]      rsp_pair_index,
   output logic [mipt_pkg::TIME_W-1:0]      rsp_start_time,
   output logic [mipt_pkg::TIME_W-1:0]      rsp_end_time,
   output logic [mipt_pkg::TIME_W-1:0]      rsp_interval,
   // Configuration write channel.
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mipt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mipt_pkg::EVENT_ID_W-1:0]  csr_wdata
);
   import mipt_pkg::*;

   localparam int NUM_ENTRIES = NUM_CPUS * NUM_PAIRS;
   localparam int ENTRY_AW    = $clog2(NUM_ENTRIES);
   localparam int CALC_W      = (ENTRY_AW > 6) ? ENTRY_AW : 6;

   ctrl_type  ctrl;
   flags_type flags;

   // Configuration.
   logic [EVENT_ID_W-1:0] start_id_ff [NUM_PAIRS];
   logic [EVENT_ID_W-1:0] end_id      [NUM_PAIRS];

   // Captured request word.
   logic                  cmd_ff;
   logic [EVENT_ID_W-1:0] ev_ff;
   logic [CPU_W-1:0]      cpu_ff;
   logic [SEQ_W-1:0]      seq_ff;
   logic                  rt_ff;
   logic [TIME_W-1:0]     time_ff;

   // Lookup results.
   logic                found_any;
   logic                found_start;
   logic [PAIR_W-1:0]   found_idx;
   logic                cpu_ok;
   logic [CALC_W-1:0]   addr_calc;
   logic [ENTRY_AW-1:0] lookup_addr;
   logic [PAIR_W-1:0]   pair_ff;
   logic                is_start_ff;
   logic [ENTRY_AW-1:0] addr_ff;

   // Work registers.
   logic [STATUS_W-1:0] res_status_ff;
   logic [TIME_W-1:0]   iv_ff;
   logic [ENTRY_AW-1:0] sweep_ff;
   logic                sweep_last;
   logic                sweeping;

   // Entry memory ports.
   held_type            held_rd;
   live_type            live_rd;
   held_type            held_wdata;
   live_type            live_wdata;
   logic                held_we;
   logic                live_we;
   logic [ENTRY_AW-1:0] wr_addr;

   // Shared subtractor.
   logic [TIME_W-1:0] alu_a;
   logic [TIME_W-1:0] alu_b;
   logic [TIME_W-1:0] alu_diff;
   logic              alu_borrow;
   logic              seq_newer;
   logic              seq_next;
   logic              arm;
   logic              lenient;
   logic              end_match;
   logic              new_max;
   logic              arm_write;

   // Output register.
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [PAIR_W-1:0]   rsp_pair_index_ff;
   logic [TIME_W-1:0]   rsp_start_time_ff;
   logic [TIME_W-1:0]   rsp_end_time_ff;
   logic [TIME_W-1:0]   rsp_interval_ff;
   logic                out_free;
   logic                rsp_load;
   logic                report;

   // Start id registers; indexes past the last pair are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_id_ff <= START_ID_RESET;
      end else if (csr_valid && csr_ready && (int'(csr_index) < NUM_PAIRS)) begin
         start_id_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
         end_id[p] = start_id_ff[p] + 8'd1;
      end
   end

   // Capture the request word.
   assign req_stall = !ctrl.idle;

   always_ff @(posedge clock) begin
      if (flags.accept) begin
         cmd_ff  <= req_cmd;
         ev_ff   <= req_event_id;
         cpu_ff  <= req_cpu_index;
         seq_ff  <= req_seq_number;
         rt_ff   <= req_is_realtime;
         time_ff <= req_time_value;
      end
   end

   // Pair lookup: the lowest matching pair wins.
   always_comb begin
      found_any   = 1'b0;
      found_start = 1'b0;
      found_idx   = '0;
      for (int p = NUM_PAIRS - 1; p >= 0; p--) begin
         if (ev_ff == start_id_ff[p] || ev_ff == end_id[p]) begin
            found_any   = 1'b1;
            found_start = (ev_ff == start_id_ff[p]);
            found_idx   = PAIR_W'(p);
         end
      end
   end

   assign cpu_ok      = (int'(cpu_ff) < NUM_CPUS);
   assign addr_calc   = (CALC_W'(cpu_ff) << 2) + (CALC_W'(cpu_ff) << 1) + CALC_W'(found_idx);
   assign lookup_addr = addr_calc[ENTRY_AW-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.lookup) begin
         pair_ff     <= found_idx;
         is_start_ff <= found_start;
         addr_ff     <= lookup_addr;
      end
   end

   // Operand selection for the shared subtractor.
   always_comb begin
      case (ctrl.alu_sel)
         ALU_SEQ: begin
            alu_a = TIME_W'(seq_ff);
            alu_b = TIME_W'(held_rd.start_seq);
         end
         ALU_INTERVAL: begin
            alu_a = time_ff;
            alu_b = held_rd.start_time;
         end
         ALU_MAX: begin
            alu_a = live_rd.max_interval;
            alu_b = iv_ff;
         end
         default: begin
            alu_a = TIME_W'(seq_ff);
            alu_b = TIME_W'(held_rd.start_seq);
         end
      endcase
   end

   mipt_sub_unit u_sub (
      .minuend    (alu_a),
      .subtrahend (alu_b),
      .diff       (alu_diff),
      .borrow     (alu_borrow)
   );

   // Decisions drawn from the subtractor in the sequence and compare steps.
   assign seq_newer = !alu_borrow && (alu_diff[SEQ_W-1:0] != '0);
   assign seq_next  = (alu_diff[SEQ_W-1:0] == SEQ_W'(1));
   assign arm       = !live_rd.waiting || (held_rd.seen && seq_newer);
   assign lenient   = (pair_ff == PAIR_TICK || pair_ff == PAIR_RESCHED) && seq_next;
   assign end_match = held_rd.seen && (rt_ff || lenient);
   assign new_max   = alu_borrow;
   assign arm_write = ctrl.seq_step && is_start_ff && arm;

   // Status and interval of the word in flight.
   always_ff @(posedge clock) begin
      if (flags.accept) begin
         res_status_ff <= STATUS_NONE;
      end else if (ctrl.lookup) begin
         res_status_ff <= flags.unregistered ? STATUS_UNREG : STATUS_NONE;
      end else if (ctrl.cmp_step) begin
         res_status_ff <= new_max ? STATUS_NEW_MAX : STATUS_NONE;
      end
      if (ctrl.iv_step) begin
         iv_ff <= alu_diff;
      end
   end

   // Sweep counter for the power-up and clear passes.
   assign sweeping   = ctrl.sweep_init || ctrl.sweep_clear;
   assign sweep_last = (sweep_ff == ENTRY_AW'(NUM_ENTRIES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (sweeping) begin
         sweep_ff <= sweep_last ? '0 : sweep_ff + 1'b1;
      end
   end

   // Entry writes.
   assign held_we = arm_write || ctrl.sweep_init;
   assign live_we = arm_write || ctrl.cmp_step || sweeping;
   assign wr_addr = sweeping ? sweep_ff : addr_ff;

   always_comb begin
      if (ctrl.sweep_init) begin
         held_wdata = '0;
      end else begin
         held_wdata.seen       = 1'b1;
         held_wdata.start_seq  = seq_ff;
         held_wdata.start_time = time_ff;
      end
   end

   always_comb begin
      if (sweeping) begin
         live_wdata = '0;
      end else if (ctrl.cmp_step) begin
         live_wdata.waiting      = 1'b0;
         live_wdata.max_interval = new_max ? iv_ff : live_rd.max_interval;
      end else begin
         live_wdata.waiting      = 1'b1;
         live_wdata.max_interval = live_rd.max_interval;
      end
   end

   mipt_entry_store #(
      .DEPTH  (NUM_ENTRIES),
      .ADDR_W (ENTRY_AW)
   ) u_store (
      .clock      (clock),
      .rd_en      (ctrl.lookup),
      .rd_addr    (lookup_addr),
      .held_rd    (held_rd),
      .live_rd    (live_rd),
      .held_we    (held_we),
      .live_we    (live_we),
      .wr_addr    (wr_addr),
      .held_wdata (held_wdata),
      .live_wdata (live_wdata)
   );

   // Flags to the sequencer.
   assign flags.accept       = req_valid && !req_stall;
   assign flags.cmd_clear    = (req_cmd == CMD_CLEAR);
   assign flags.unregistered = !cpu_ok || !found_any || (cmd_ff == CMD_CLEAR);
   assign flags.is_start     = is_start_ff;
   assign flags.end_match    = end_match;
   assign flags.sweep_last   = sweep_last;
   assign flags.out_free     = out_free;

   mipt_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   // Output register: loads when the previous word has left or is leaving.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = ctrl.result && out_free;
   assign report   = (res_status_ff == STATUS_NEW_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff     <= res_status_ff;
         rsp_pair_index_ff <= report ? pair_ff : '0;
         rsp_start_time_ff <= report ? held_rd.start_time : '0;
         rsp_end_time_ff   <= report ? time_ff : '0;
         rsp_interval_ff   <= report ? iv_ff : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_pair_index = rsp_pair_index_ff;
   assign rsp_start_time = rsp_start_time_ff;
   assign rsp_end_time   = rsp_end_time_ff;
   assign rsp_interval   = rsp_interval_ff;

endmodule

FILE: src/mipt_checker.sv
`include "max_interval_pair_tracker_defines.svh"

module mipt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [mipt_pkg::STATUS_W-1:0]    rsp_status,
   input logic [mipt_pkg::PAIR_W-1:0]      rsp_pair_index,
   input logic [mipt_pkg::TIME_W-1:0]      rsp_start_time,
   input logic [mipt_pkg::TIME_W-1:0]      rsp_end_time,
   input logic [mipt_pkg::TIME_W-1:0]      rsp_interval
);
   import mipt_pkg::*;

   // A reported maximum is the end time minus the start time.
   `MIPT_ASSERT_NOW(a_interval_is_diff, clock, reset, rsp_valid && rsp_status == STATUS_NEW_MAX, rsp_interval == rsp_end_time - rsp_start_time, "interval does not match end minus start")

   // A new maximum beats a stored value of at least zero, so it is never zero.
   `MIPT_ASSERT_NOW(a_new_max_nonzero, clock, reset, rsp_valid && rsp_status == STATUS_NEW_MAX, rsp_interval != '0, "new maximum of zero reported")

   // Words without a new maximum carry zero in every other field.
   `MIPT_ASSERT_NOW(a_other_fields_zero, clock, reset, rsp_valid && rsp_status != STATUS_NEW_MAX, rsp_pair_index == '0 && rsp_start_time == '0 && rsp_end_time == '0 && rsp_interval == '0, "fields set without a new maximum")

   // The block holds off further requests while it works on one.
   `MIPT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "request taken while busy")

   // A stalled result word holds.
   `MIPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status) && $stable(rsp_interval), "stalled result changed")

endmodule

bind max_interval_pair_tracker mipt_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_pair_index (rsp_pair_index),
   .rsp_start_time (rsp_start_time),
   .rsp_end_time   (rsp_end_time),
   .rsp_interval   (rsp_interval)
);

FILE: bench/max_interval_pair_tracker_tb.sv
module max_interval_pair_tracker_tb;
   import mipt_pkg::*;

   localparam int N_CPUS       = 8;
   localparam int N_ENTRIES    = N_CPUS * NUM_PAIRS;
   localparam int RANDOM_WORDS = 400;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_AFTER   = 900;
   localparam int MAX_PRINTED  = 40;

   // Register map of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PAIR0_START,
      REG_PAIR1_START,
      REG_PAIR2_START,
      REG_PAIR3_START,
      REG_PAIR4_START,
      REG_PAIR5_START,
      REG_SPARE6,
      REG_SPARE7
   } csr_reg_type;

   // Patterns the result side uses to stall.
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_ALTERNATE
   } stall_style_type;

   typedef struct packed {
      logic                  cmd;
      logic [EVENT_ID_W-1:0] event_id;
      logic [CPU_W-1:0]      cpu_index;
      logic [SEQ_W-1:0]      seq_number;
      logic                  is_realtime;
      logic [TIME_W-1:0]     time_value;
   } event_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PAIR_W-1:0]   pair_index;
      logic [TIME_W-1:0]   start_time;
      logic [TIME_W-1:0]   end_time;
      logic [TIME_W-1:0]   interval;
   } report_word_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_cmd = CMD_EVENT;
   logic [EVENT_ID_W-1:0]  req_event_id = '0;
   logic [CPU_W-1:0]       req_cpu_index = '0;
   logic [SEQ_W-1:0]       req_seq_number = '0;
   logic                   req_is_realtime = 1'b0;
   logic [TIME_W-1:0]      req_time_value = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [PAIR_W-1:0]      rsp_pair_index;
   logic [TIME_W-1:0]      rsp_start_time;
   logic [TIME_W-1:0]      rsp_end_time;
   logic [TIME_W-1:0]      rsp_interval;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [EVENT_ID_W-1:0]  csr_wdata = '0;

   // Shadow configuration and tracker state.
   logic [EVENT_ID_W-1:0] pair_start_id [NUM_PAIRS];
   bit                    waiting_end [N_ENTRIES];
   bit                    start_seen [N_ENTRIES];
   logic [TIME_W-1:0]     held_time [N_ENTRIES];
   logic [SEQ_W-1:0]      held_seq [N_ENTRIES];
   logic [TIME_W-1:0]     peak_interval [N_ENTRIES];

   // Stimulus generator state: last start sequence and time per entry.
   logic [SEQ_W-1:0]      gen_seq [N_ENTRIES];
   logic [TIME_W-1:0]     gen_time [N_ENTRIES];

   event_word_type  pending_words [$];
   report_word_type expected_reports [$];
   event_word_type  word_now;
   event_word_type  next_word;
   report_word_type want;

   int unsigned  cycle_count = 0;
   int unsigned  words_accepted = 0;
   int unsigned  results_seen = 0;
   int unsigned  csr_writes = 0;
   int unsigned  clear_count = 0;
   int unsigned  new_max_count = 0;
   int unsigned  unreg_count = 0;
   int unsigned  errors = 0;
   int unsigned  burst_left = 1;
   int unsigned  gap_left = 0;
   int unsigned  rsp_taken = 0;
   int unsigned  hold_left = 0;
   int unsigned  style_left = 0;
   bit           long_hold_done = 1'b0;
   bit           stall_next;
   stall_style_type stall_style = STALL_NONE;

   max_interval_pair_tracker #(
      .NUM_CPUS(N_CPUS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_event_id(req_event_id),
      .req_cpu_index(req_cpu_index),
      .req_seq_number(req_seq_number),
      .req_is_realtime(req_is_realtime),
      .req_time_value(req_time_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_pair_index(rsp_pair_index),
      .rsp_start_time(rsp_start_time),
      .rsp_end_time(rsp_end_time),
      .rsp_interval(rsp_interval),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= MAX_PRINTED) begin
         $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      end
   endtask

   // Applies one word to the shadow tracker and returns the report it should produce.
   function automatic report_word_type track_event(input event_word_type w);
      report_word_type r;
      int found;
      int e;
      bit is_start;
      bit lenient;
      logic [EVENT_ID_W-1:0] end_id;
      logic [SEQ_W-1:0] next_seq;
      logic [TIME_W-1:0] span;
      r = '0;
      found = -1;
      is_start = 1'b0;
      if (w.cmd == CMD_CLEAR) begin
         for (e = 0; e < N_ENTRIES; e++) begin
            waiting_end[e] = 1'b0;
            peak_interval[e] = '0;
         end
         clear_count++;
         return r;
      end
      // The lowest pair whose start or end id matches wins.
      if (int'(w.cpu_index) < N_CPUS) begin
         for (int p = 0; p < NUM_PAIRS; p++) begin
            end_id = pair_start_id[p] + 8'd1;
            if (found < 0 && (w.event_id == pair_start_id[p] || w.event_id == end_id)) begin
               found = p;
               is_start = (w.event_id == pair_start_id[p]);
            end
         end
      end
      if (found < 0) begin
         r.status = STATUS_UNREG;
         unreg_count++;
         return r;
      end
      e = int'(w.cpu_index) * NUM_PAIRS + found;
      if (is_start) begin
         // An armed entry is only re-armed by a newer sequence number.
         if (!waiting_end[e] || (start_seen[e] && held_seq[e] < w.seq_number)) begin
            waiting_end[e] = 1'b1;
            start_seen[e] = 1'b1;
            held_time[e] = w.time_value;
            held_seq[e] = w.seq_number;
         end
         return r;
      end
      // The end check ignores the waiting flag; the held start stays for later ends.
      if (start_seen[e]) begin
         next_seq = held_seq[e] + 32'd1;
         lenient = (found == int'(PAIR_TICK) || found == int'(PAIR_RESCHED)) &&
                   next_seq == w.seq_number;
         if (w.is_realtime || lenient) begin
            span = w.time_value - held_time[e];
            waiting_end[e] = 1'b0;
            if (span > peak_interval[e]) begin
               peak_interval[e] = span;
               r.status = STATUS_NEW_MAX;
               r.pair_index = PAIR_W'(found);
               r.start_time = held_time[e];
               r.end_time = w.time_value;
               r.interval = span;
               new_max_count++;
            end
         end
      end
      return r;
   endfunction

   function automatic event_word_type make_event(input logic cmd, input logic [7:0] id,
                                                 input int cpu, input logic [31:0] seq,
                                                 input logic rt, input logic [63:0] t);
      event_word_type w;
      w.cmd = cmd;
      w.event_id = id;
      w.cpu_index = CPU_W'(cpu);
      w.seq_number = seq;
      w.is_realtime = rt;
      w.time_value = t;
      return w;
   endfunction

   function automatic logic [EVENT_ID_W-1:0] end_id_of(input int p);
      return pair_start_id[p] + 8'd1;
   endfunction

   // Mostly start/end sequences per entry with random content, plus noise and clears.
   function automatic event_word_type random_word();
      event_word_type w;
      int roll;
      int cpu;
      int p;
      int e;
      logic [TIME_W-1:0] span;
      roll = $urandom_range(0, 99);
      w = make_event(CMD_EVENT, EVENT_ID_W'($urandom), $urandom_range(0, 7), $urandom,
                     1'($urandom), {$urandom, $urandom});
      if (roll < 2) begin
         w.cmd = CMD_CLEAR;
      end else if (roll >= 10) begin
         cpu = $urandom_range(0, N_CPUS - 1);
         p = $urandom_range(0, NUM_PAIRS - 1);
         e = cpu * NUM_PAIRS + p;
         w.cpu_index = CPU_W'(cpu);
         w.is_realtime = ($urandom_range(0, 1) == 1);
         if ($urandom_range(0, 1) == 1) begin
            w.event_id = pair_start_id[p];
            if ($urandom_range(0, 9) != 0) begin
               gen_seq[e] = gen_seq[e] + $urandom_range(0, 2);
               w.seq_number = gen_seq[e];
            end
            gen_time[e] = gen_time[e] + $urandom_range(1, 5000);
            w.time_value = gen_time[e];
         end else begin
            w.event_id = end_id_of(p);
            if ($urandom_range(0, 4) != 0) begin
               w.seq_number = gen_seq[e] + 32'd1;
            end
            // Spans of widely varying size; now and then one that wraps.
            if ($urandom_range(0, 29) == 0) begin
               span = {$urandom, $urandom};
            end else begin
               span = {$urandom, $urandom} >> $urandom_range(20, 63);
            end
            w.time_value = gen_time[e] + span;
         end
      end
      return w;
   endfunction

   task automatic add_random_words(input int count);
      for (int e = 0; e < N_ENTRIES; e++) begin
         gen_seq[e] = $urandom;
         gen_time[e] = {$urandom, $urandom} >> $urandom_range(0, 8);
      end
      repeat (count) pending_words.push_back(random_word());
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [EVENT_ID_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx <= REG_PAIR5_START) begin
         pair_start_id[idx] = value;
      end
      csr_writes++;
   endtask

   task automatic program_pairs(input logic [7:0] a0, input logic [7:0] a1,
                                input logic [7:0] a2, input logic [7:0] a3,
                                input logic [7:0] a4, input logic [7:0] a5);
      logic [NUM_PAIRS-1:0][EVENT_ID_W-1:0] ids;
      ids = {a5, a4, a3, a2, a1, a0};
      for (int i = 0; i < NUM_PAIRS; i++) begin
         write_reg(csr_reg_type'(i), ids[i]);
      end
   endtask

   // Sampled on the falling edge so the check does not race the clocked blocks.
   task automatic wait_all_returned();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_reports.size() != 0);
   endtask

   // Sender: words go out in bursts with random gaps; a stalled word is held.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            word_now = {req_cmd, req_event_id, req_cpu_index, req_seq_number,
                        req_is_realtime, req_time_value};
            expected_reports.push_back(track_event(word_now));
            words_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               next_word = pending_words.pop_front();
               req_valid <= 1'b1;
               req_cmd <= next_word.cmd;
               req_event_id <= next_word.event_id;
               req_cpu_index <= next_word.cpu_index;
               req_seq_number <= next_word.seq_number;
               req_is_realtime <= next_word.is_realtime;
               req_time_value <= next_word.time_value;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern changes at random intervals, with one long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_taken++;
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (!long_hold_done && rsp_taken >= HOLD_AFTER) begin
            hold_left = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (style_left == 0) begin
            stall_style = stall_style_type'($urandom_range(0, 3));
            style_left = $urandom_range(20, 200);
         end else begin
            style_left--;
         end
         case (stall_style)
            STALL_NONE: stall_next = 1'b0;
            STALL_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
            STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
            default: stall_next = !rsp_stall;
         endcase
         rsp_stall <= stall_next || (hold_left > 0);
      end
   end

   // Result checker: each accepted word against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_reports.size() == 0) begin
            report_mismatch("result arrived with no word outstanding");
         end else begin
            want = expected_reports.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                         results_seen, rsp_status, want.status));
            if (rsp_pair_index !== want.pair_index)
               report_mismatch($sformatf("result %0d pair %0d, expected %0d",
                                         results_seen, rsp_pair_index, want.pair_index));
            if (rsp_start_time !== want.start_time)
               report_mismatch($sformatf("result %0d start time %h, expected %h",
                                         results_seen, rsp_start_time, want.start_time));
            if (rsp_end_time !== want.end_time)
               report_mismatch($sformatf("result %0d end time %h, expected %h",
                                         results_seen, rsp_end_time, want.end_time));
            if (rsp_interval !== want.interval)
               report_mismatch($sformatf("result %0d interval %h, expected %h",
                                         results_seen, rsp_interval, want.interval));
         end
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timed out after %0d cycles: %0d words queued, %0d results outstanding.",
               cycle_count, pending_words.size(), expected_reports.size());
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      for (int i = 0; i < NUM_PAIRS; i++) begin
         pair_start_id[i] = START_ID_RESET[i];
      end
      for (int e = 0; e < N_ENTRIES; e++) begin
         waiting_end[e] = 1'b0;
         start_seen[e] = 1'b0;
         held_time[e] = '0;
         held_seq[e] = '0;
         peak_interval[e] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset ids: arming, re-arming, strict and lenient ends, wraps, clear.
      pending_words.push_back(make_event(CMD_EVENT, end_id_of(0), 0, 0, 1'b1, 64'd10));
      pending_words.push_back(make_event(CMD_EVENT, pair_start_id[0], 0, 5, 1'b0, 64'd1000));
      pending_words.push_back(make_event(CMD_EVENT, pair_start_id[0], 0, 5, 1'b0, 64'd2000));
      pending_words.push_back(make_event(CMD_EVENT, pair_start_id[0], 0, 6, 1'b1, 64'd1500));
      pending_words.push_back(make_event(CMD_EVENT, end_id_of(0), 0, 7, 1'b0, 64'd1600));
      pending_words.push_back(make_event(CMD_EVENT, end_id_of(0), 0, 7, 1'b1, 64'd1600));
      pending_words.push_back(make_event(CMD_EVENT, end_id_of(0), 0, 9, 1'b1, 64'd1650));
      pending_words.push_back(make_event(CMD_EVENT, end_id_of(0), 0, 9, 1'b1, 64'd1620));
      pending_words.push_back(make_event(CMD_EVENT, pair_start_id[1], 2, 32'hFFFF_FFFE, 1'b1,
                                         64'h8000_0000_0000_0000));
      pending_words.push_back(make_event(CMD_EVENT, end_id_of(1), 2, 0, 1'b1,
                                         64'h8000_0000_0000_0001));
      pending_words.push_back(make_event(CMD_EVENT, pair_start_id[2], 1, 0, 1'b0, 64'd500));
      pending_words.push_back(make_event(CMD_EVENT, end_id_of(2), 1, 1, 1'b1, 64'd100));
      pending_words.push_back(make_event(CMD_EVENT, pair_start_id[3], 4, 100, 1'b0, 64'd0));
      pending_words.push_back(make_event(CMD_EVENT, pair_start_id[3], 4, 99, 1'b0, 64'd50));
      pending_words.push_back(make_event(CMD_EVENT, end_id_of(3), 4, 101, 1'b1, '1));
      pending_words.push_back(make_event(CMD_EVENT, pair_start_id[PAIR_TICK], 7, 32'hFFFF_FFFF,
                                         1'b0, 64'hFFFF_FFFF_FFFF_FFF0));
      pending_words.push_back(make_event(CMD_EVENT, end_id_of(PAIR_TICK), 7, 0, 1'b0, 64'h10));
      pending_words.push_back(make_event(CMD_EVENT, pair_start_id[PAIR_RESCHED], 3, 10, 1'b0,
                                         64'd0));
      pending_words.push_back(make_event(CMD_EVENT, end_id_of(PAIR_RESCHED), 3, 12, 1'b0,
                                         64'd5));
      pending_words.push_back(make_event(CMD_EVENT, end_id_of(PAIR_RESCHED), 3, 11, 1'b0, '1));
      pending_words.push_back(make_event(CMD_EVENT, 8'd0, 0, 0, 1'b0, 64'd0));
      pending_words.push_back(make_event(CMD_EVENT, 8'hFF, 7, 32'hFFFF_FFFF, 1'b1, '1));
      pending_words.push_back(make_event(CMD_CLEAR, 8'hFF, 7, 32'hFFFF_FFFF, 1'b1, '1));
      // After a clear the held start remains, so this end reports a fresh maximum.
      pending_words.push_back(make_event(CMD_EVENT, end_id_of(0), 0, 9, 1'b1, 64'd1650));
      add_random_words(RANDOM_WORDS);
      wait_all_returned();

      // Extreme and overlapping ids; the spare indexes must be ignored.
      program_pairs(8'd0, 8'd255, 8'd254, 8'd1, 8'd128, 8'd127);
      write_reg(REG_SPARE6, 8'hFF);
      write_reg(REG_SPARE7, 8'h00);
      pending_words.push_back(make_event(CMD_EVENT, 8'd255, 1, 3, 1'b0, 64'd20));
      pending_words.push_back(make_event(CMD_EVENT, 8'd0, 1, 4, 1'b1, 64'd40));
      pending_words.push_back(make_event(CMD_EVENT, 8'd128, 1, 5, 1'b1, 64'd60));
      add_random_words(RANDOM_WORDS);
      wait_all_returned();

      // Random ids.
      program_pairs(EVENT_ID_W'($urandom), EVENT_ID_W'($urandom), EVENT_ID_W'($urandom),
                    EVENT_ID_W'($urandom), EVENT_ID_W'($urandom), EVENT_ID_W'($urandom));
      add_random_words(RANDOM_WORDS);
      wait_all_returned();

      // Reschedule pair at id 255, so its end id wraps to zero.
      program_pairs(8'd20, 8'd40, 8'd60, 8'd80, 8'd100, 8'd255);
      pending_words.push_back(make_event(CMD_EVENT, pair_start_id[PAIR_RESCHED], 5, 1, 1'b0,
                                         64'd7));
      pending_words.push_back(make_event(CMD_EVENT, end_id_of(PAIR_RESCHED), 5, 2, 1'b0,
                                         64'd9));
      add_random_words(RANDOM_WORDS);
      wait_all_returned();

      // Back to the reset ids.
      program_pairs(START_ID_RESET[0], START_ID_RESET[1], START_ID_RESET[2],
                    START_ID_RESET[3], START_ID_RESET[4], START_ID_RESET[5]);
      add_random_words(RANDOM_WORDS);
      wait_all_returned();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_reports.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));
      end
      $display("Sent %0d event words under five id settings,", words_accepted);
      $display("with %0d register writes and %0d clears.", csr_writes, clear_count);
      $display("Checked %0d results: %0d new maxima, %0d unregistered events, %0d mismatches.",
               results_seen, new_max_count, unreg_count, errors);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
